/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define RNR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define RNR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rnr_pkg.sv */
package rnr_pkg;

    // Default size limits
    localparam int MAX_OUT_WIDTH_DEF  = 128;
    localparam int MAX_OUT_HEIGHT_DEF = 128;
    localparam int MAX_SRC_WIDTH_DEF  = 1024;
    localparam int MAX_SRC_HEIGHT_DEF = 1024;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_OUT_WIDTH  = 3'd2,
        CFG_OUT_HEIGHT = 3'd3,
        CFG_CHANNELS   = 3'd4,
        CFG_FLOAT_MODE = 3'd5,
        CFG_SIGNED     = 3'd6
    } t_cfg_idx;

    // Register reset values
    localparam logic [10:0] RST_SRC_WIDTH  = 11'd320;
    localparam logic [10:0] RST_SRC_HEIGHT = 11'd240;
    localparam logic [7:0]  RST_OUT_WIDTH  = 8'd128;
    localparam logic [7:0]  RST_OUT_HEIGHT = 8'd128;
    localparam logic [1:0]  RST_CHANNELS   = 2'd3;

    // Payload widths
    localparam int IDX_W  = 14;
    localparam int CHAN_W = 16;

    localparam logic [CHAN_W-1:0] INT8_OFFSET = 16'd128;

    typedef struct packed {
        logic [15:0] pixel;
        logic        frame_start;
    } t_pix_req;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [CHAN_W-1:0] chan_red;
        logic signed [CHAN_W-1:0] chan_green;
        logic signed [CHAN_W-1:0] chan_blue;
        logic                     frame_last;
    } t_res;

    typedef logic [7:0]        t_exp5 [32];
    typedef logic [7:0]        t_exp6 [64];
    typedef logic [CHAN_W-1:0] t_enc5 [32];
    typedef logic [CHAN_W-1:0] t_enc6 [64];

    // Q2.14 of v/255 or 2v/255-1, round to nearest (elaboration only)
    function automatic int f_q(int v, bit sgn);
        int n;
        int m;
        if (!sgn) begin
            m = (v * 32768 + 255) / 510;
        end else if (v >= 128) begin
            n = (2 * v - 255) * 16384;
            m = (n * 2 + 255) / 510;
        end else begin
            n = (255 - 2 * v) * 16384;
            m = 0 - ((n * 2 + 255) / 510);
        end
        return m;
    endfunction

    function automatic t_exp5 f_tab_exp5();
        t_exp5 t;
        for (int i = 0; i < 32; i++) begin
            t[i] = 8'((i * 255) / 31);
        end
        return t;
    endfunction

    function automatic t_exp6 f_tab_exp6();
        t_exp6 t;
        for (int i = 0; i < 64; i++) begin
            t[i] = 8'((i * 255) / 63);
        end
        return t;
    endfunction

    function automatic t_enc5 f_tab_q5(bit sgn);
        t_enc5 t;
        for (int i = 0; i < 32; i++) begin
            t[i] = 16'(f_q((i * 255) / 31, sgn));
        end
        return t;
    endfunction

    function automatic t_enc6 f_tab_q6(bit sgn);
        t_enc6 t;
        for (int i = 0; i < 64; i++) begin
            t[i] = 16'(f_q((i * 255) / 63, sgn));
        end
        return t;
    endfunction

    // Channel expansion and Q2.14 tables
    localparam t_exp5 EXP5 = f_tab_exp5();
    localparam t_exp6 EXP6 = f_tab_exp6();
    localparam t_enc5 QU5  = f_tab_q5(1'b0);
    localparam t_enc5 QS5  = f_tab_q5(1'b1);
    localparam t_enc6 QU6  = f_tab_q6(1'b0);
    localparam t_enc6 QS6  = f_tab_q6(1'b1);

    // Encode a 5-bit channel code in the selected output form
    function automatic logic [CHAN_W-1:0] f_enc5(logic [4:0] code, logic fm, logic sr);
        logic [CHAN_W-1:0] res;
        if (!fm) begin
            res = {8'h00, EXP5[code]} - INT8_OFFSET;
        end else if (sr) begin
            res = QS5[code];
        end else begin
            res = QU5[code];
        end
        return res;
    endfunction

    // Encode a 6-bit channel code in the selected output form
    function automatic logic [CHAN_W-1:0] f_enc6(logic [5:0] code, logic fm, logic sr);
        logic [CHAN_W-1:0] res;
        if (!fm) begin
            res = {8'h00, EXP6[code]} - INT8_OFFSET;
        end else if (sr) begin
            res = QS6[code];
        end else begin
            res = QU6[code];
        end
        return res;
    endfunction

endpackage

/* rtl/rnr_stream_if.sv */
interface rnr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rgb565_nearest_resize_normalize_unit.sv */
// A kept pixel is registered in the hold stage (r_a_*) and then in r_res before
// it shows on o_res. Throughput: one pixel per cycle while i_pix.ready is high;
// dropped pixels produce no result. Input ready stays low during a config write
// and under output back-pressure, and after reset and after each width or height
// register write, while two restoring dividers form source/output step sizes.
// Reset is synchronous, active low; it loads the register defaults.
`include "assert_macros.svh"

module rgb565_nearest_resize_normalize_unit #(
    parameter int MAX_OUT_WIDTH  = rnr_pkg::MAX_OUT_WIDTH_DEF,
    parameter int MAX_OUT_HEIGHT = rnr_pkg::MAX_OUT_HEIGHT_DEF,
    parameter int MAX_SRC_WIDTH  = rnr_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = rnr_pkg::MAX_SRC_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rnr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rnr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rnr_stream_if.sink                     i_pix,
    rnr_stream_if.source                   o_res
);
    import rnr_pkg::*;

    localparam int SW_W   = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SH_W   = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int OW_W   = $clog2(MAX_OUT_WIDTH + 1);
    localparam int OH_W   = $clog2(MAX_OUT_HEIGHT + 1);
    localparam int DW     = (SW_W > SH_W) ? SW_W : SH_W;
    localparam int DVW    = (OW_W > OH_W) ? OW_W : OH_W;
    localparam int DCNT_W = $clog2(DW + 1);
    localparam int CT_W   = $clog2(2 * MAX_SRC_WIDTH + 1);
    localparam int RT_W   = $clog2(2 * MAX_SRC_HEIGHT + 1);
    localparam int RS_W   = ((DVW > 8) ? DVW : 8) + 1;
    localparam int PR_W   = OH_W + OW_W;
    localparam int PW     = (PR_W + 1 > IDX_W) ? PR_W + 1 : IDX_W;

    // Configuration registers
    logic [10:0] r_cfg_sw;
    logic [10:0] r_cfg_sh;
    logic [7:0]  r_cfg_ow;
    logic [7:0]  r_cfg_oh;
    logic [1:0]  r_cfg_ch;
    logic        r_cfg_fm;
    logic        r_cfg_sr;
    logic        dim_wr;

    // Effective dimensions
    logic [SW_W-1:0] sw;
    logic [SH_W-1:0] sh;
    logic [OW_W-1:0] ow;
    logic [OH_W-1:0] oh;
    logic [OW_W-1:0] ow_c;
    logic [OH_W-1:0] oh_c;

    // Step-size dividers
    logic              r_div_busy;
    logic              r_div_load;
    logic [DCNT_W-1:0] r_div_cnt;
    logic [DW-1:0]     r_dq_w;
    logic [DW-1:0]     r_dq_h;
    logic [DVW-1:0]    r_dr_w;
    logic [DVW-1:0]    r_dr_h;
    logic [DVW-1:0]    r_dd_w;
    logic [DVW-1:0]    r_dd_h;
    logic [DVW:0]      dsh_w;
    logic [DVW:0]      dsh_h;
    logic              dge_w;
    logic              dge_h;

    // Position counters
    logic [SW_W-1:0] r_src_col, c_src_col, n_src_col, col_inc;
    logic [SH_W-1:0] r_src_row, c_src_row, n_src_row, row_inc;
    logic [OW_W-1:0] r_ncol, c_ncol, n_ncol;
    logic [OH_W-1:0] r_nrow, c_nrow, n_nrow;
    logic [CT_W-1:0] r_col_tgt, c_col_tgt, n_col_tgt, col_tgt_adv;
    logic [RT_W-1:0] r_row_tgt, c_row_tgt, n_row_tgt, row_tgt_adv;
    logic [7:0]      r_col_rem, c_col_rem, n_col_rem, col_rem_adv;
    logic [7:0]      r_row_rem, c_row_rem, n_row_rem, row_rem_adv;
    logic [RS_W-1:0] col_sum, row_sum;
    logic            col_ge, row_ge;
    logic            row_hit, hit;
    logic [PR_W-1:0] idx_prod;
    logic [PW-1:0]   idx_full;

    // Pipeline
    logic              acc_in;
    logic              out_free;
    logic              a_move;
    logic              r_a_vld;
    logic [15:0]       r_a_pix;
    logic [IDX_W-1:0]  r_a_idx;
    logic              r_a_last;
    logic              r_out_vld;
    t_res              r_res;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sw <= RST_SRC_WIDTH;
            r_cfg_sh <= RST_SRC_HEIGHT;
            r_cfg_ow <= RST_OUT_WIDTH;
            r_cfg_oh <= RST_OUT_HEIGHT;
            r_cfg_ch <= RST_CHANNELS;
            r_cfg_fm <= 1'b0;
            r_cfg_sr <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_WIDTH:  r_cfg_sw <= i_cfg_data[10:0];
                CFG_SRC_HEIGHT: r_cfg_sh <= i_cfg_data[10:0];
                CFG_OUT_WIDTH:  r_cfg_ow <= i_cfg_data[7:0];
                CFG_OUT_HEIGHT: r_cfg_oh <= i_cfg_data[7:0];
                CFG_CHANNELS:   r_cfg_ch <= i_cfg_data[1:0];
                CFG_FLOAT_MODE: r_cfg_fm <= i_cfg_data[0];
                CFG_SIGNED:     r_cfg_sr <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign dim_wr = i_cfg_we && (i_cfg_idx == CFG_SRC_WIDTH || i_cfg_idx == CFG_SRC_HEIGHT
                    || i_cfg_idx == CFG_OUT_WIDTH || i_cfg_idx == CFG_OUT_HEIGHT);

    // Clamp dimensions to 1..MAX, output not above source
    always_comb begin
        if (r_cfg_sw == '0) begin
            sw = SW_W'(1);
        end else if (32'(r_cfg_sw) > 32'(MAX_SRC_WIDTH)) begin
            sw = SW_W'(MAX_SRC_WIDTH);
        end else begin
            sw = SW_W'(r_cfg_sw);
        end
        if (r_cfg_sh == '0) begin
            sh = SH_W'(1);
        end else if (32'(r_cfg_sh) > 32'(MAX_SRC_HEIGHT)) begin
            sh = SH_W'(MAX_SRC_HEIGHT);
        end else begin
            sh = SH_W'(r_cfg_sh);
        end
        if (r_cfg_ow == '0) begin
            ow_c = OW_W'(1);
        end else if (32'(r_cfg_ow) > 32'(MAX_OUT_WIDTH)) begin
            ow_c = OW_W'(MAX_OUT_WIDTH);
        end else begin
            ow_c = OW_W'(r_cfg_ow);
        end
        if (r_cfg_oh == '0) begin
            oh_c = OH_W'(1);
        end else if (32'(r_cfg_oh) > 32'(MAX_OUT_HEIGHT)) begin
            oh_c = OH_W'(MAX_OUT_HEIGHT);
        end else begin
            oh_c = OH_W'(r_cfg_oh);
        end
        ow = (32'(ow_c) > 32'(sw)) ? OW_W'(sw) : ow_c;
        oh = (32'(oh_c) > 32'(sh)) ? OH_W'(sh) : oh_c;
    end

    // One restoring division step for each axis
    always_comb begin
        dsh_w = {r_dr_w, r_dq_w[DW-1]};
        dsh_h = {r_dr_h, r_dq_h[DW-1]};
        dge_w = dsh_w >= {1'b0, r_dd_w};
        dge_h = dsh_h >= {1'b0, r_dd_h};
    end

    // Run the dividers after reset and after each dimension write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b1;
            r_div_load <= 1'b1;
            r_div_cnt  <= '0;
        end else if (dim_wr) begin
            r_div_busy <= 1'b1;
            r_div_load <= 1'b1;
        end else if (r_div_load) begin
            r_div_load <= 1'b0;
            r_div_cnt  <= DCNT_W'(DW);
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt - 1'b1;
            if (r_div_cnt == DCNT_W'(1)) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_div_load) begin
            r_dq_w <= DW'(sw);
            r_dq_h <= DW'(sh);
            r_dr_w <= '0;
            r_dr_h <= '0;
            r_dd_w <= DVW'(ow);
            r_dd_h <= DVW'(oh);
        end else if (r_div_busy) begin
            r_dq_w <= {r_dq_w[DW-2:0], dge_w};
            r_dq_h <= {r_dq_h[DW-2:0], dge_h};
            r_dr_w <= dge_w ? DVW'(dsh_w - {1'b0, r_dd_w}) : DVW'(dsh_w);
            r_dr_h <= dge_h ? DVW'(dsh_h - {1'b0, r_dd_h}) : DVW'(dsh_h);
        end
    end

    // Handshake
    assign out_free    = !r_out_vld || o_res.ready;
    assign a_move      = r_a_vld && out_free;
    assign i_pix.ready = !r_div_busy && !i_cfg_we && (!r_a_vld || out_free);
    assign acc_in      = i_pix.valid && i_pix.ready;

    // Target advance by quotient and remainder
    always_comb begin
        col_sum     = RS_W'(c_col_rem) + RS_W'(r_dr_w);
        col_ge      = col_sum >= RS_W'(ow);
        col_rem_adv = col_ge ? 8'(col_sum - RS_W'(ow)) : 8'(col_sum);
        col_tgt_adv = c_col_tgt + CT_W'(r_dq_w) + CT_W'(col_ge);
        row_sum     = RS_W'(c_row_rem) + RS_W'(r_dr_h);
        row_ge      = row_sum >= RS_W'(oh);
        row_rem_adv = row_ge ? 8'(row_sum - RS_W'(oh)) : 8'(row_sum);
        row_tgt_adv = c_row_tgt + RT_W'(r_dq_h) + RT_W'(row_ge);
    end

    // Select the pixel and step the counters
    always_comb begin
        if (i_pix.data.frame_start) begin
            c_src_col = '0;
            c_src_row = '0;
            c_ncol    = '0;
            c_nrow    = '0;
            c_col_tgt = '0;
            c_row_tgt = '0;
            c_col_rem = '0;
            c_row_rem = '0;
        end else begin
            c_src_col = r_src_col;
            c_src_row = r_src_row;
            c_ncol    = r_ncol;
            c_nrow    = r_nrow;
            c_col_tgt = r_col_tgt;
            c_row_tgt = r_row_tgt;
            c_col_rem = r_col_rem;
            c_row_rem = r_row_rem;
        end

        row_hit = (RT_W'(c_src_row) == c_row_tgt) && (c_nrow < oh);
        hit     = row_hit && (CT_W'(c_src_col) == c_col_tgt) && (c_ncol < ow);

        n_src_row = c_src_row;
        n_nrow    = c_nrow;
        n_row_tgt = c_row_tgt;
        n_row_rem = c_row_rem;
        n_ncol    = c_ncol;
        n_col_tgt = c_col_tgt;
        n_col_rem = c_col_rem;
        if (hit) begin
            n_ncol    = c_ncol + 1'b1;
            n_col_tgt = col_tgt_adv;
            n_col_rem = col_rem_adv;
        end

        col_inc   = c_src_col + 1'b1;
        row_inc   = c_src_row + 1'b1;
        n_src_col = col_inc;
        if (col_inc >= sw) begin
            n_src_col = '0;
            n_ncol    = '0;
            n_col_tgt = '0;
            n_col_rem = '0;
            if (row_hit) begin
                n_nrow    = c_nrow + 1'b1;
                n_row_tgt = row_tgt_adv;
                n_row_rem = row_rem_adv;
            end
            n_src_row = row_inc;
            // wrap at the end of the frame
            if (row_inc >= sh) begin
                n_src_row = '0;
                n_nrow    = '0;
                n_row_tgt = '0;
                n_row_rem = '0;
            end
        end

        idx_prod = PR_W'(c_nrow) * PR_W'(ow);
        idx_full = PW'(idx_prod) + PW'(c_ncol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col <= '0;
            r_src_row <= '0;
            r_ncol    <= '0;
            r_nrow    <= '0;
            r_col_tgt <= '0;
            r_row_tgt <= '0;
            r_col_rem <= '0;
            r_row_rem <= '0;
        end else if (acc_in) begin
            r_src_col <= n_src_col;
            r_src_row <= n_src_row;
            r_ncol    <= n_ncol;
            r_nrow    <= n_nrow;
            r_col_tgt <= n_col_tgt;
            r_row_tgt <= n_row_tgt;
            r_col_rem <= n_col_rem;
            r_row_rem <= n_row_rem;
        end
    end

    // Hold a kept pixel until the result register takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (acc_in && hit) begin
            r_a_vld <= 1'b1;
        end else if (a_move) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in && hit) begin
            r_a_pix  <= i_pix.data.pixel;
            r_a_idx  <= idx_full[IDX_W-1:0];
            r_a_last <= (c_nrow == oh - 1'b1) && (c_ncol == ow - 1'b1);
        end
    end

    // Expand, encode and register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (a_move) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_res.out_index  <= r_a_idx;
            r_res.chan_red   <= (r_cfg_ch >= 2'd1)
                                ? $signed(f_enc5(r_a_pix[15:11], r_cfg_fm, r_cfg_sr)) : '0;
            r_res.chan_green <= (r_cfg_ch >= 2'd2)
                                ? $signed(f_enc6(r_a_pix[10:5], r_cfg_fm, r_cfg_sr)) : '0;
            r_res.chan_blue  <= (r_cfg_ch >= 2'd3)
                                ? $signed(f_enc5(r_a_pix[4:0], r_cfg_fm, r_cfg_sr)) : '0;
            r_res.frame_last <= r_a_last;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_res;

    `RNR_ASSERT_NXT(a_dim_wr_busy, i_clk, i_rst_n, dim_wr, r_div_busy && r_div_load, "dimension write did not restart the dividers")
    `RNR_ASSERT_IMP(a_div_result, i_clk, i_rst_n, $fell(r_div_busy), (32'(r_dq_w) * 32'(ow) + 32'(r_dr_w) == 32'(sw)) && (32'(r_dq_h) * 32'(oh) + 32'(r_dr_h) == 32'(sh)), "divider quotient or remainder wrong")
    `RNR_ASSERT_NXT(a_frame_first, i_clk, i_rst_n, i_pix.valid && i_pix.ready && i_pix.data.frame_start, r_a_vld && r_a_idx == '0, "first pixel of a frame not kept as output zero")

endmodule
